// ----- src/gspid_pkg.sv -----
package gspid_pkg;

   // Field widths
   localparam int unsigned DATA_W      = 16;
   localparam int unsigned ERR_W       = 17;
   localparam int unsigned SUM_W       = 21;
   localparam int unsigned CSR_DATA_W  = 64;

   // Default number of schedule bands
   localparam int unsigned BANDS_DEFAULT = 4;

   // Register indexes
   localparam int unsigned CSR_MIN_OUTPUT = 0;
   localparam int unsigned CSR_MAX_OUTPUT = 1;
   localparam int unsigned CSR_BAND_BASE  = 2;

   // One schedule band as packed in its register
   typedef struct packed {
      logic signed [15:0] bound;
      logic [15:0]        kp;
      logic [15:0]        ki;
      logic [15:0]        kd;
   } band_type;

   // Controller state carried from item to item
   typedef struct packed {
      logic signed [SUM_W-1:0] error_sum;
      logic signed [ERR_W-1:0] last_error;
   } state_type;

   // Datapath result: next state and the output sample
   typedef struct packed {
      state_type                nxt;
      logic signed [DATA_W-1:0] drive;
   } core_out_type;

endpackage

// ----- src/gspid_core.sv -----
module gspid_core import gspid_pkg::*; #(
   parameter int unsigned SCHEDULE_BANDS = BANDS_DEFAULT
) (
   input  logic signed [DATA_W-1:0] setpoint,
   input  logic signed [DATA_W-1:0] measured,
   input  logic signed [DATA_W-1:0] min_output,
   input  logic signed [DATA_W-1:0] max_output,
   input  band_type                 band [SCHEDULE_BANDS],
   input  state_type                state,
   output core_out_type             result
);

   band_type           gains;
   logic               found;
   logic signed [16:0] err;
   logic signed [21:0] err_acc;
   logic signed [17:0] err_diff;
   logic signed [33:0] p_prod;
   logic signed [38:0] i_prod;
   logic signed [34:0] d_prod;
   logic signed [40:0] p_wide;
   logic signed [40:0] pid_sum;
   logic signed [40:0] lo16;
   logic signed [40:0] hi16;
   logic               clear;
   logic               accum;
   logic signed [21:0] sum_upd;
   logic signed [21:0] sum_lo;
   logic signed [21:0] sum_hi;
   logic signed [21:0] sum_clamped;
   logic signed [40:0] rounded;
   logic signed [24:0] q;
   logic signed [24:0] q_lo;
   logic signed [24:0] q_hi;
   logic signed [24:0] q_clamped;

   // Pick the first band whose bound covers the target, else the last one
   always_comb begin
      gains = band[SCHEDULE_BANDS-1];
      found = 1'b0;
      for (int i = 0; i < SCHEDULE_BANDS; i++) begin
         if (!found && (setpoint <= band[i].bound)) begin
            gains = band[i];
            found = 1'b1;
         end
      end
   end

   // Error terms
   assign err      = $signed({setpoint[DATA_W-1], setpoint})
                   - $signed({measured[DATA_W-1], measured});
   assign err_acc  = $signed({state.error_sum[SUM_W-1], state.error_sum})
                   + $signed({{5{err[16]}}, err});
   assign err_diff = $signed({err[16], err})
                   - $signed({state.last_error[ERR_W-1], state.last_error});

   // Gain products, gains are unsigned Q0.16
   assign p_prod = $signed({1'b0, gains.kp}) * err;
   assign i_prod = $signed({1'b0, gains.ki}) * err_acc;
   assign d_prod = $signed({1'b0, gains.kd}) * err_diff;

   assign p_wide  = 41'(p_prod);
   assign pid_sum = p_wide + 41'(i_prod) + 41'(d_prod);

   // Output limits scaled to the Q.16 sum
   assign lo16 = $signed({{9{min_output[DATA_W-1]}}, min_output, 16'b0});
   assign hi16 = $signed({{9{max_output[DATA_W-1]}}, max_output, 16'b0});

   // Anti-windup: clear on proportional overshoot, else accumulate inside limits
   assign clear = ((max_output != '0) && (p_wide > hi16))
               || ((min_output != '0) && (p_wide < lo16));
   assign accum = ((min_output == '0) || (pid_sum > lo16))
               && ((max_output == '0) || (pid_sum < hi16));

   assign sum_lo = $signed({{2{min_output[DATA_W-1]}}, min_output, 4'b0});
   assign sum_hi = $signed({{2{max_output[DATA_W-1]}}, max_output, 4'b0});

   always_comb begin
      if (clear) begin
         sum_upd = '0;
      end else if (accum) begin
         sum_upd = err_acc;
      end else begin
         sum_upd = $signed({state.error_sum[SUM_W-1], state.error_sum});
      end
      // Lower bound is checked first; with crossed limits, values below it take it, the rest the upper bound
      if (sum_upd < sum_lo) begin
         sum_clamped = sum_lo;
      end else if (sum_upd > sum_hi) begin
         sum_clamped = sum_hi;
      end else begin
         sum_clamped = sum_upd;
      end
   end

   // Round half up to an integer, then clamp to min then max
   assign rounded = pid_sum + 41'sd32768;
   assign q       = rounded[40:16];
   assign q_lo    = 25'(min_output);
   assign q_hi    = 25'(max_output);

   always_comb begin
      if (q < q_lo) begin
         q_clamped = q_lo;
      end else if (q > q_hi) begin
         q_clamped = q_hi;
      end else begin
         q_clamped = q;
      end
   end

   assign result.nxt.error_sum  = sum_clamped[SUM_W-1:0];
   assign result.nxt.last_error = err;
   assign result.drive          = q_clamped[DATA_W-1:0];

endmodule

// ----- src/gain_scheduled_pid_step.sv -----
// Gain-scheduled PID step with integrator anti-windup.
// A req transfer passes the input register, then the result register, to reach rsp_tvalid.
// Throughput: one item per cycle while rsp does not stall; the integrator state updates as each item advances.
// Backpressure on rsp stalls the result register, then the input register.
// Reset (synchronous, active high) clears valids, integrator, last error and all
// configuration registers to zero.
module gain_scheduled_pid_step import gspid_pkg::*; #(
   parameter int unsigned SCHEDULE_BANDS = BANDS_DEFAULT,
   parameter int unsigned CSR_INDEX_W    = $clog2(CSR_BAND_BASE + SCHEDULE_BANDS)
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: [15:0] setpoint, [31:16] measured
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,
   // rsp_tdata: [15:0] drive
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic signed [DATA_W-1:0] min_output_ff;
   logic signed [DATA_W-1:0] max_output_ff;
   band_type                 band_ff [SCHEDULE_BANDS];
   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic signed [DATA_W-1:0] setpoint_ff;
   logic signed [DATA_W-1:0] measured_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] drive_ff;
   state_type                state_ff;
   core_out_type             core_out;
   logic                     req_xfer;
   logic                     advance;

   // Configuration writes; out-of-range indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         min_output_ff <= '0;
         max_output_ff <= '0;
         for (int b = 0; b < SCHEDULE_BANDS; b++) begin
            band_ff[b] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_INDEX_W'(CSR_MIN_OUTPUT)) begin
            min_output_ff <= csr_wdata[DATA_W-1:0];
         end
         if (csr_index == CSR_INDEX_W'(CSR_MAX_OUTPUT)) begin
            max_output_ff <= csr_wdata[DATA_W-1:0];
         end
         for (int b = 0; b < SCHEDULE_BANDS; b++) begin
            if (csr_index == CSR_INDEX_W'(CSR_BAND_BASE + b)) begin
               band_ff[b] <= csr_wdata;
            end
         end
      end
   end

   // Handshake: the input register advances when the result register frees up
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_xfer    = req_tvalid && req_tready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= core_out.nxt;
         end
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         setpoint_ff <= req_tdata[15:0];
         measured_ff <= req_tdata[31:16];
      end
      if (advance) begin
         drive_ff <= core_out.drive;
      end
   end

   gspid_core #(
      .SCHEDULE_BANDS(SCHEDULE_BANDS)
   ) u_core (
      .setpoint   (setpoint_ff),
      .measured   (measured_ff),
      .min_output (min_output_ff),
      .max_output (max_output_ff),
      .band       (band_ff),
      .state      (state_ff),
      .result     (core_out)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

endmodule

// ----- src/gspid_check.sv -----
module gspid_check import gspid_pkg::*; #(
   parameter int unsigned CSR_INDEX_W = 3
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [31:0]            req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [15:0]            rsp_tdata,
   input logic                   csr_we,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic signed [DATA_W-1:0] min_ff;
   logic signed [DATA_W-1:0] max_ff;
   logic [1:0]               pending_ff;
   logic [1:0]               pending_in;
   logic                     req_xfer;
   logic                     rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // Track items in flight
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   // Shadow the output limits
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= '0;
         max_ff     <= '0;
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (csr_we && (csr_index == CSR_INDEX_W'(CSR_MIN_OUTPUT))) begin
            min_ff <= csr_wdata[DATA_W-1:0];
         end
         if (csr_we && (csr_index == CSR_INDEX_W'(CSR_MAX_OUTPUT))) begin
            max_ff <= csr_wdata[DATA_W-1:0];
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 2'd0))
      else $error("result without an accepted item");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more items in flight than registers");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (min_ff <= max_ff) |->
         ($signed(rsp_tdata) >= min_ff) && ($signed(rsp_tdata) <= max_ff))
      else $error("drive outside output limits");

endmodule

bind gain_scheduled_pid_step gspid_check #(
   .CSR_INDEX_W(CSR_INDEX_W)
) u_gspid_check (.*);

// ----- bench/tb_gain_scheduled_pid_step.sv -----
`timescale 1ns / 100ps

import gspid_pkg::*;

// Tracks the controller state and the expected drive values in transfer order
class drive_scoreboard;
   logic signed [DATA_W-1:0] lim_lo;
   logic signed [DATA_W-1:0] lim_hi;
   band_type                 bands[BANDS_DEFAULT];
   logic signed [SUM_W-1:0]  integ;
   logic signed [ERR_W-1:0]  prev_err;
   logic [DATA_W-1:0]        expected_drive[$];
   int                       mismatches;
   int                       checked;

   function new();
      lim_lo     = '0;
      lim_hi     = '0;
      integ      = '0;
      prev_err   = '0;
      mismatches = 0;
      checked    = 0;
      foreach (bands[i]) bands[i] = '0;
   endfunction

   // Mirror one register write; indexes past the last band are dropped
   function void write_csr(int unsigned idx, logic [CSR_DATA_W-1:0] value);
      if (idx == CSR_MIN_OUTPUT)
         lim_lo = value[DATA_W-1:0];
      else if (idx == CSR_MAX_OUTPUT)
         lim_hi = value[DATA_W-1:0];
      else if (idx < CSR_BAND_BASE + BANDS_DEFAULT)
         bands[idx - CSR_BAND_BASE] = value;
   endfunction

   // Advance the controller by one accepted sample and queue its drive value
   function void note_sample(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] mv);
      int       sel;
      band_type b;
      longint   err, p_term, total, lo_q16, hi_q16, lo_q4, hi_q4, acc, rnd;
      sel = BANDS_DEFAULT - 1;
      for (int i = 0; i < BANDS_DEFAULT; i++) begin
         if (longint'(sp) <= longint'($signed(bands[i].bound))) begin
            sel = i;
            break;
         end
      end
      b = bands[sel];
      err    = longint'(sp) - longint'(mv);
      p_term = longint'(b.kp) * err;
      total  = p_term + longint'(b.ki) * (longint'(integ) + err)
               + longint'(b.kd) * (err - longint'(prev_err));
      lo_q16 = longint'(lim_lo) * 65536;
      hi_q16 = longint'(lim_hi) * 65536;
      lo_q4  = longint'(lim_lo) * 16;
      hi_q4  = longint'(lim_hi) * 16;

      // Anti-windup: clear on a saturated P term, else integrate inside the limits
      acc = longint'(integ);
      if ((lim_hi != 0 && p_term > hi_q16) || (lim_lo != 0 && p_term < lo_q16))
         acc = 0;
      else if ((lim_lo == 0 || total > lo_q16) && (lim_hi == 0 || total < hi_q16))
         acc = acc + err;
      if (acc < lo_q4)
         acc = lo_q4;
      else if (acc > hi_q4)
         acc = hi_q4;
      integ    = acc[SUM_W-1:0];
      prev_err = err[ERR_W-1:0];

      // Round half up, then clamp low limit first
      rnd = (total + 32768) >>> 16;
      if (rnd < longint'(lim_lo))
         rnd = longint'(lim_lo);
      else if (rnd > longint'(lim_hi))
         rnd = longint'(lim_hi);
      expected_drive.push_back(rnd[DATA_W-1:0]);
   endfunction

   // Compare one drive transfer with the oldest expectation
   function void check_drive(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (expected_drive.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: drive %0d arrived with no sample pending", $realtime, $signed(got));
         return;
      end
      want = expected_drive.pop_front();
      checked++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: drive mismatch, expected %0d, got %0d",
                     $realtime, $signed(want), $signed(got));
      end
   endfunction

   function int pending();
      return expected_drive.size();
   endfunction
endclass

module tb_gain_scheduled_pid_step;

   localparam int NUM_REGS  = CSR_BAND_BASE + BANDS_DEFAULT;
   localparam int CSR_IDX_W = $clog2(CSR_BAND_BASE + BANDS_DEFAULT);

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   drive_scoreboard       sb = new();
   logic [CSR_DATA_W-1:0] reg_image[NUM_REGS];
   bit                    steady     = 1'b0;
   int                    samples_sent = 0;
   int                    settings   = 0;

   gain_scheduled_pid_step DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: stall at random with probability 8 in 100, never during a steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 8);
   end

   // Watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_sample(req_tdata[15:0], req_tdata[31:16]);
            samples_sent++;
         end
         if (rsp_tvalid && rsp_tready)
            sb.check_drive(rsp_tdata);
      end
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Present one sample and hold it until the transfer
   task automatic send_sample(input logic [15:0] sp, input logic [15:0] mv);
      while (!steady && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mv, sp};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off the sender until every expected drive value has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic settle();
      drain();
      repeat (4) @(posedge clock);
   endtask

   // Write every index, including the unused ones above the last band
   task automatic program_regs();
      for (int idx = 0; idx < 2 ** CSR_IDX_W; idx++) begin
         logic [CSR_DATA_W-1:0] value;
         value = (idx < NUM_REGS) ? reg_image[idx] : {$urandom, $urandom};
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(idx);
         csr_wdata <= value;
         @(posedge clock);
         sb.write_csr(idx, value);
      end
      csr_we <= 1'b0;
      settings++;
   endtask

   // Limits carry random upper bits, which the block must ignore
   task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi);
      logic [CSR_DATA_W-1:0] tmp;
      tmp = {$urandom, $urandom};
      tmp[15:0] = lo;
      reg_image[CSR_MIN_OUTPUT] = tmp;
      tmp = {$urandom, $urandom};
      tmp[15:0] = hi;
      reg_image[CSR_MAX_OUTPUT] = tmp;
   endtask

   task automatic set_band(input int j, input logic [15:0] bound, input logic [15:0] kp,
                           input logic [15:0] ki, input logic [15:0] kd);
      reg_image[CSR_BAND_BASE + j] = {bound, kp, ki, kd};
   endtask

   // Change only the limits, then push two samples through
   task automatic limit_case(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] sp0, input logic [15:0] mv0,
                             input logic [15:0] sp1, input logic [15:0] mv1);
      settle();
      set_limits(lo, hi);
      program_regs();
      send_sample(sp0, mv0);
      send_sample(sp1, mv1);
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1, 2:    return 16'($urandom);
         default: return 16'($urandom_range(0, 16'h0800));
      endcase
   endfunction

   // One random setting followed by a burst of samples aimed at the band edges
   task automatic random_phase(input int count, input bit pause_mid);
      logic [15:0] lo, hi, sp, mv;
      int          m, bnd, j, tmp;
      bit          ordered;
      settle();
      case ($urandom_range(0, 5))
         0: begin
            lo = 16'($urandom);
            hi = 16'($urandom);
         end
         1: begin
            lo = 16'h8000;
            hi = 16'h7FFF;
         end
         2: begin
            lo = '0;
            hi = 16'($urandom_range(1, 3000));
         end
         3: begin
            lo = 16'(-$urandom_range(1, 3000));
            hi = '0;
         end
         4: begin
            m  = $urandom_range(1, 2000);
            lo = 16'(-m);
            hi = 16'(m);
         end
         default: begin
            lo = 16'($urandom_range(0, 400));
            hi = 16'(-$urandom_range(0, 400));
         end
      endcase
      set_limits(lo, hi);

      // Mostly rising bounds; sometimes a scrambled table
      ordered = $urandom_range(0, 4) != 0;
      bnd = -$urandom_range(0, 3000);
      for (int b = 0; b < BANDS_DEFAULT; b++) begin
         if (ordered) begin
            bnd = bnd + $urandom_range(0, 1500);
            tmp = bnd;
         end else begin
            tmp = $urandom;
         end
         set_band(b, tmp[15:0], pick_gain(), pick_gain(), pick_gain());
      end
      program_regs();

      for (int k = 0; k < count; k++) begin
         if (pause_mid && k == count / 2)
            drain();
         if ($urandom_range(0, 9) < 7) begin
            j   = $urandom_range(0, BANDS_DEFAULT - 1);
            tmp = int'($signed(reg_image[CSR_BAND_BASE + j][63:48]))
                  + $urandom_range(0, 8) - 4;
            sp  = tmp[15:0];
         end else begin
            sp = 16'($urandom);
         end
         if ($urandom_range(0, 3) != 0) begin
            tmp = int'($signed(sp)) - ($urandom_range(0, 600) - 300);
            mv  = tmp[15:0];
         end else begin
            mv = 16'($urandom);
         end
         send_sample(sp, mv);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: both limits zero, drive stays zero
      send_sample(16'd100, -16'sd50);
      send_sample(16'h8000, 16'h7FFF);
      send_sample(16'h7FFF, 16'h8000);
      settle();

      // Four bands with distinct gains; limits +/-100
      set_limits(-16'sd100, 16'sd100);
      set_band(0, -16'sd1600, 16'h0800, 16'h0000, 16'h0000);
      set_band(1, 16'sd0,     16'h1000, 16'h0100, 16'h0400);
      set_band(2, 16'sd1600,  16'hFFFF, 16'hFFFF, 16'hFFFF);
      set_band(3, 16'sd3200,  16'h0000, 16'h0040, 16'h2000);
      program_regs();
      // Half-way ties on the first band bound, both signs
      send_sample(-16'sd1600, -16'sd1616);
      send_sample(-16'sd1700, -16'sd1684);
      // Largest negative error clears the integrator
      send_sample(16'h8000, 16'h7FFF);
      // Integrate on the second band
      send_sample(16'sd0, -16'sd32);
      send_sample(16'sd0, -16'sd32);
      send_sample(-16'sd20, 16'sd40);
      // Full-scale gains saturate the output
      send_sample(16'sd1, 16'sd0);
      send_sample(16'sd1600, 16'sd1700);
      // Last band, and a target above every bound
      send_sample(16'sd1601, 16'sd1601);
      send_sample(16'h7FFF, 16'h8000);
      send_sample(16'sd3200, 16'sd3190);
      send_sample(16'sd3200, 16'sd3190);

      // Limit corner cases: zero, crossed, one side disabled, full scale
      limit_case(16'sd0, 16'sd0, 16'sd500, 16'sd0, -16'sd500, 16'sd300);
      limit_case(16'sd200, -16'sd200, 16'sd10, 16'sd0, -16'sd10, 16'sd0);
      limit_case(16'sd0, 16'sd500, 16'sd1000, 16'sd900, -16'sd40, 16'sd0);
      limit_case(-16'sd300, 16'sd0, -16'sd900, 16'sd700, 16'sd20, 16'sd0);
      limit_case(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);

      // Random settings; one phase without idling, one with a mid-phase drain
      for (int ph = 0; ph < 10; ph++) begin
         steady = (ph == 3);
         random_phase(125, ph == 5);
      end
      steady = 1'b0;

      settle();
      repeat (10) @(posedge clock);
      $display("Sent %0d samples across %0d register settings (reset, zero, crossed,",
               samples_sent, settings);
      $display("one-sided and full-scale limits); %0d drive values compared",
               sb.checked);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
